// ===== design/assert_macros.svh =====
// Assertion macros used by the checker in tcw_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

// Checked also while reset is asserted.
`define CHK_ALWAYS(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) (pre) |-> (post)) \
        else $error("assertion failed");

`endif

// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps
package tcw_pkg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in_word;

    typedef struct packed {
        logic [10:0] cursor_position;
        logic [15:0] cell_data;
    } t_out_word;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] K_CHAR      = 3'd0;
    localparam logic [2:0] K_NEWLINE   = 3'd1;
    localparam logic [2:0] K_BACKSPACE = 3'd2;
    localparam logic [2:0] K_CLEAR     = 3'd3;
    localparam logic [2:0] K_READ      = 3'd4;
    localparam logic [2:0] K_NOP       = 3'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
        logic        in_range;
    } t_cmd;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] FIXED_ATTR   = 8'h07;

    localparam logic REG_ATTR = 1'b0;
    localparam logic REG_MODE = 1'b1;

endpackage

// ===== design/text_console_writer_core.sv =====
`timescale 1ns / 1ps
// Text console writer. Words on the input channel put a character, clear the
// screen or read one cell; every input word yields exactly one output word
// with the cursor position after it and, for a read, the cell contents.
// Both channels move a word when valid is high and stall is low. Settings
// are written through the configuration channel, which is always ready;
// the user must change them only while no word is in flight, and the block
// itself does not enforce this. A two-word queue decouples acceptance from
// execution, so until it is full the input side keeps taking words while a
// result waits on a stalled receiver. A character or newline that does not
// scroll goes from idle straight to the result state; a backspace that moves
// the cursor blanks the cell in S_BS_WR and a read waits in S_RD_WAIT. A
// scroll copies moved cells in S_COPY and blanks the freed row in S_BLANK,
// sparing the reserved rows in that mode; a clear refills all cells in S_FILL.
// The screen memory has a single write port. After reset the block blanks
// the whole screen memory with stall held high on the input channel;
// configuration writes are still taken then. A stalled result holds until
// taken; meanwhile the engine may run the next word, then waits to send it.
module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  tcw_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output tcw_pkg::t_out_word o_out_word,
    input  logic               i_out_stall,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import tcw_pkg::*;

    logic [7:0] r_text_attr;
    logic       r_reserved;
    logic       hold;
    logic       cmd_valid;
    t_cmd       cmd;
    logic       pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= FIXED_ATTR;
            r_reserved  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_ATTR: r_text_attr <= i_cfg_data;
                REG_MODE: r_reserved  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .i_hold      (hold),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (pop)
    );

    tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text_attr (r_text_attr),
        .i_reserved  (r_reserved),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_hold      (hold),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );
endmodule

// ===== design/tcw_ram.sv =====
`timescale 1ns / 1ps
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/tcw_front.sv =====
`timescale 1ns / 1ps
module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tcw_pkg::t_in_word i_in_word,
    output logic              o_in_stall,
    input  logic              i_hold,
    output logic              o_cmd_valid,
    output tcw_pkg::t_cmd     o_cmd,
    input  logic              i_pop
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       cls;
    logic       push;

    always_comb begin
        cls.char_code  = i_in_word.char_code;
        cls.cell_index = i_in_word.cell_index;
        cls.in_range   = (32'(i_in_word.cell_index) < 32'(CELL_COUNT));
        unique case (i_in_word.opcode)
            OP_PUT: begin
                if (i_in_word.char_code == CH_NEWLINE) begin
                    cls.kind = K_NEWLINE;
                end else if (i_in_word.char_code == CH_BACKSPACE) begin
                    cls.kind = K_BACKSPACE;
                end else begin
                    cls.kind = K_CHAR;
                end
            end
            OP_CLEAR: cls.kind = K_CLEAR;
            OP_READ:  cls.kind = K_READ;
            default:  cls.kind = K_NOP;
        endcase
    end

    assign o_in_stall  = i_hold || (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule

// ===== design/tcw_back.sv =====
`timescale 1ns / 1ps
module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_text_attr,
    input  logic               i_reserved,
    input  logic               i_cmd_valid,
    input  tcw_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_hold,
    output logic               o_out_valid,
    output tcw_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);

    localparam logic [AW:0] N_COPY_BEG = (AW+1)'(COLUMNS);
    localparam logic [AW:0] R_COPY_BEG = (AW+1)'(2 * COLUMNS);
    localparam logic [AW:0] N_END      = (AW+1)'(ROWS * COLUMNS);
    localparam logic [AW:0] R_END      = (AW+1)'((ROWS - 1) * COLUMNS);
    localparam logic [AW:0] N_BLANK    = (AW+1)'((ROWS - 1) * COLUMNS);
    localparam logic [AW:0] R_BLANK    = (AW+1)'((ROWS - 2) * COLUMNS);
    localparam logic [AW:0] FILL_LAST  = (AW+1)'(CELL_COUNT - 1);
    localparam logic [AW-1:0] COL_STEP = AW'(COLUMNS);
    localparam logic [RW:0] N_LIMIT    = (RW+1)'(ROWS);
    localparam logic [RW:0] R_LIMIT    = (RW+1)'(ROWS - 1);
    localparam logic [RW-1:0] N_LAST   = RW'(ROWS - 1);
    localparam logic [RW-1:0] R_LAST   = RW'(ROWS - 2);
    localparam logic [CW-1:0] COL_MAX  = CW'(COLUMNS - 1);

    localparam logic [2:0] S_FILL    = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_BS_WR   = 3'd2;
    localparam logic [2:0] S_RD_WAIT = 3'd3;
    localparam logic [2:0] S_COPY    = 3'd4;
    localparam logic [2:0] S_BLANK   = 3'd5;
    localparam logic [2:0] S_RESULT  = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [AW:0]   r_addr, n_addr;
    logic          r_fill_res, n_fill_res;
    logic [7:0]    r_fill_attr, n_fill_attr;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          r_scroll, n_scroll;
    logic          r_rd_ok, n_rd_ok;
    logic [AW-1:0] r_bs_addr, n_bs_addr;
    logic          r_cp_pend, n_cp_pend;
    logic [AW-1:0] r_cp_dst, n_cp_dst;
    logic [15:0]   r_data, n_data;
    logic          r_out_valid;
    t_out_word     r_out_word;

    logic [7:0]    cur_attr;
    logic [AW-1:0] pos;
    logic [AW+10:0] idx_ext;
    logic [CW-1:0] adv_col;
    logic [RW:0]   adv_row;
    logic          need_scroll;
    logic [RW-1:0] last_row;
    logic [AW:0]   copy_beg, area_end, blank_beg;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata, rdata;
    logic          out_free;
    logic [AW-1:0] cur_pos;
    logic [AW+10:0] pos_ext;

    tcw_ram #(.WIDTH(16), .DEPTH(CELL_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign cur_attr  = i_reserved ? FIXED_ATTR : i_text_attr;
    assign pos       = AW'(r_row) * COL_STEP + AW'(r_col);
    assign idx_ext   = (AW+11)'(i_cmd.cell_index);
    assign last_row  = i_reserved ? R_LAST : N_LAST;
    assign copy_beg  = i_reserved ? R_COPY_BEG : N_COPY_BEG;
    assign area_end  = i_reserved ? R_END : N_END;
    assign blank_beg = i_reserved ? R_BLANK : N_BLANK;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_pop     = (r_state == S_IDLE) && i_cmd_valid;
    assign o_hold    = (r_state == S_FILL) && !r_fill_res;

    always_comb begin
        adv_col = r_col;
        adv_row = (RW+1)'(r_row);
        unique case (i_cmd.kind)
            K_NEWLINE: begin
                adv_col = '0;
                adv_row = (RW+1)'(r_row) + (RW+1)'(1);
            end
            K_BACKSPACE: begin
                if (r_col != '0) begin
                    adv_col = r_col - CW'(1);
                end
            end
            K_CHAR: begin
                if (r_col == COL_MAX) begin
                    adv_col = '0;
                    adv_row = (RW+1)'(r_row) + (RW+1)'(1);
                end else begin
                    adv_col = r_col + CW'(1);
                end
            end
            default: ;
        endcase
        need_scroll = ((i_cmd.kind == K_CHAR) || (i_cmd.kind == K_NEWLINE)
                       || (i_cmd.kind == K_BACKSPACE))
                      && (adv_row >= (i_reserved ? R_LIMIT : N_LIMIT));
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_fill_res  = r_fill_res;
        n_fill_attr = r_fill_attr;
        n_col       = r_col;
        n_row       = r_row;
        n_scroll    = r_scroll;
        n_rd_ok     = r_rd_ok;
        n_bs_addr   = r_bs_addr;
        n_cp_pend   = r_cp_pend;
        n_cp_dst    = r_cp_dst;
        n_data      = r_data;
        we          = 1'b0;
        waddr       = r_addr[AW-1:0];
        wdata       = {r_fill_attr, BLANK_CHAR};
        raddr       = r_addr[AW-1:0];
        unique case (r_state)
            S_FILL: begin
                we = 1'b1;
                n_addr = r_addr + (AW+1)'(1);
                if (r_addr == FILL_LAST) begin
                    n_state = r_fill_res ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_data   = '0;
                    n_col    = adv_col;
                    n_row    = need_scroll ? last_row : adv_row[RW-1:0];
                    n_scroll = need_scroll;
                    n_addr   = copy_beg;
                    n_cp_pend = 1'b0;
                    n_state  = need_scroll ? S_COPY : S_RESULT;
                    unique case (i_cmd.kind)
                        K_CHAR: begin
                            we    = 1'b1;
                            waddr = pos;
                            wdata = {cur_attr, i_cmd.char_code};
                        end
                        K_BACKSPACE: begin
                            if (r_col != '0) begin
                                raddr     = pos - AW'(1);
                                n_bs_addr = pos - AW'(1);
                                n_state   = S_BS_WR;
                            end
                        end
                        K_CLEAR: begin
                            n_col       = '0;
                            n_row       = '0;
                            n_addr      = '0;
                            n_fill_res  = 1'b1;
                            n_fill_attr = cur_attr;
                            n_state     = S_FILL;
                        end
                        K_READ: begin
                            raddr   = idx_ext[AW-1:0];
                            n_rd_ok = i_cmd.in_range;
                            n_state = S_RD_WAIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_BS_WR: begin
                we      = 1'b1;
                waddr   = r_bs_addr;
                wdata   = {rdata[15:8], BLANK_CHAR};
                n_state = r_scroll ? S_COPY : S_RESULT;
            end
            S_RD_WAIT: begin
                n_data  = r_rd_ok ? rdata : '0;
                n_state = S_RESULT;
            end
            S_COPY: begin
                we    = r_cp_pend;
                waddr = r_cp_dst;
                wdata = rdata;
                if (r_addr < area_end) begin
                    n_cp_pend = 1'b1;
                    n_cp_dst  = r_addr[AW-1:0] - COL_STEP;
                    n_addr    = r_addr + (AW+1)'(1);
                end else begin
                    n_cp_pend = 1'b0;
                    if (!r_cp_pend) begin
                        n_addr  = blank_beg;
                        n_state = S_BLANK;
                    end
                end
            end
            S_BLANK: begin
                we     = 1'b1;
                wdata  = {cur_attr, BLANK_CHAR};
                n_addr = r_addr + (AW+1)'(1);
                if (r_addr == area_end - (AW+1)'(1)) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_fill_res = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign cur_pos = AW'(r_row) * COL_STEP + AW'(r_col);
    assign pos_ext = (AW+11)'(cur_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_addr      <= '0;
            r_fill_res  <= 1'b0;
            r_fill_attr <= FIXED_ATTR;
            r_col       <= '0;
            r_row       <= '0;
            r_scroll    <= 1'b0;
            r_cp_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_fill_res  <= n_fill_res;
            r_fill_attr <= n_fill_attr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_scroll    <= n_scroll;
            r_cp_pend   <= n_cp_pend;
            if (r_state == S_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok   <= n_rd_ok;
        r_bs_addr <= n_bs_addr;
        r_cp_dst  <= n_cp_dst;
        r_data    <= n_data;
        if (r_state == S_RESULT && out_free) begin
            r_out_word.cursor_position <= pos_ext[10:0];
            r_out_word.cell_data       <= r_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
endmodule

// ===== design/tcw_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input tcw_pkg::t_out_word o_out_word,
    input logic               i_out_stall
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;

    logic [2:0] r_pend;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 3'(in_acc) - 3'(out_acc);
        end
    end

    // A word waiting on a stalled receiver keeps its contents.
    `CHK_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))
    // No result appears without an accepted input word behind it.
    `CHK_NOW(a_no_extra, o_out_valid, r_pend != 3'd0)
    // The reported cursor always lies on the screen.
    `CHK_NOW(a_cursor_rng, o_out_valid,
             (CELL_COUNT > 2048) || (32'(o_out_word.cursor_position) < 32'(CELL_COUNT)))
    // The first cycle after reset shows no result.
    `CHK_ALWAYS(a_reset_quiet, $past(!i_rst_n) && i_rst_n, !o_out_valid)
endmodule

bind text_console_writer_core tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tcw_checker (.*);

// ===== dv/text_console_writer_core_tb.sv =====
`timescale 1ns / 1ps
module text_console_writer_core_tb;
    import tcw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = ROWS * COLUMNS;
    localparam int PHASES = 6;
    localparam int PHASE_WORDS = 100;
    localparam int DRAIN_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 10_000_000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in_word in_word = '0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_index = REG_ATTR;
    logic [7:0] cfg_data = 8'h00;

    logic o_in_stall;
    logic o_out_valid;
    t_out_word o_out_word;
    logic o_cfg_ready;

    logic [15:0] screen_mem [0:CELLS-1];
    int unsigned cur_col = 0;
    int unsigned cur_row = 0;
    logic [7:0] attr_reg = 8'h07;
    logic mode_reg = 1'b0;

    t_in_word cmd_backlog [$];
    t_out_word due_replies [$];
    bit gaps_on = 1'b1;
    int unsigned feed_gap = 0;
    int unsigned stall_left = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;
    int unsigned n_scrolls = 0;
    int unsigned n_clears = 0;
    int unsigned n_reads = 0;
    longint cycle_count = 0;

    text_console_writer_core #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .i_in_word(in_word),
        .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_word(o_out_word),
        .i_out_stall(out_stall),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [7:0] active_attr();
        return mode_reg ? FIXED_ATTR : attr_reg;
    endfunction

    function automatic void scroll_text();
        int unsigned first;
        int unsigned last;
        first = mode_reg ? 1 : 0;
        last = (mode_reg ? ROWS - 1 : ROWS) - 1;
        for (int unsigned r = first; r < last; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
                screen_mem[r * COLUMNS + c] = screen_mem[(r + 1) * COLUMNS + c];
            end
        end
        for (int c = 0; c < COLUMNS; c++) begin
            screen_mem[last * COLUMNS + c] = {active_attr(), BLANK_CHAR};
        end
        cur_row = last;
        n_scrolls++;
    endfunction

    function automatic void put_byte(logic [7:0] ch);
        int unsigned pos;
        pos = cur_row * COLUMNS + cur_col;
        if (ch == CH_NEWLINE) begin
            cur_col = 0;
            cur_row++;
        end else if (ch == CH_BACKSPACE) begin
            if (cur_col > 0) begin
                cur_col--;
                pos = cur_row * COLUMNS + cur_col;
                screen_mem[pos][7:0] = BLANK_CHAR;
            end
        end else begin
            screen_mem[pos] = {active_attr(), ch};
            cur_col++;
        end
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= (mode_reg ? ROWS - 1 : ROWS)) begin
            scroll_text();
        end
    endfunction

    function automatic t_out_word apply_console_cmd(t_in_word w);
        t_out_word r;
        r.cell_data = '0;
        case (w.opcode)
            OP_PUT: begin
                put_byte(w.char_code);
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen_mem[i] = {active_attr(), BLANK_CHAR};
                end
                cur_col = 0;
                cur_row = 0;
                n_clears++;
            end
            OP_READ: begin
                if (w.cell_index < CELLS) begin
                    r.cell_data = screen_mem[w.cell_index];
                end
                n_reads++;
            end
            default: begin
            end
        endcase
        r.cursor_position = 11'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        if (!gaps_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic t_in_word random_cmd(int unsigned nl_pct);
        t_in_word w;
        int unsigned r;
        int unsigned s;
        w.opcode = OP_PUT;
        w.char_code = 8'($urandom_range(0, 255));
        w.cell_index = 11'($urandom_range(0, 2047));
        r = $urandom_range(0, 99);
        if (r < nl_pct) begin
            w.char_code = CH_NEWLINE;
        end else if (r < nl_pct + 7) begin
            w.char_code = CH_BACKSPACE;
        end else if (r < nl_pct + 9) begin
            w.opcode = OP_CLEAR;
        end else if (r < nl_pct + 11) begin
            w.opcode = OP_UNUSED;
        end else if (r < nl_pct + 30) begin
            w.opcode = OP_READ;
            s = $urandom_range(0, 9);
            if (s < 4) begin
                w.cell_index = 11'($urandom_range(CELLS - 3 * COLUMNS, CELLS - 1));
            end else if (s < 7) begin
                w.cell_index = 11'($urandom_range(0, 3 * COLUMNS - 1));
            end else if (s < 9) begin
                w.cell_index = 11'($urandom_range(0, CELLS - 1));
            end else begin
                w.cell_index = 11'($urandom_range(CELLS, 2047));
            end
        end else if ($urandom_range(0, 99) < 85) begin
            w.char_code = 8'($urandom_range(32, 126));
        end
        return w;
    endfunction

    task automatic queue_cmd(logic [1:0] op, logic [7:0] ch, logic [10:0] idx);
        t_in_word w;
        w.opcode = op;
        w.char_code = ch;
        w.cell_index = idx;
        cmd_backlog.push_back(w);
    endtask

    task automatic cfg_write(logic idx, logic [7:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_ATTR) begin
            attr_reg = data;
        end else begin
            mode_reg = data[0];
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || in_valid || due_replies.size() != 0);
    endtask

    always @(posedge i_clk) begin : feed_proc
        logic nxt_valid;
        t_in_word nxt_word;
        nxt_valid = in_valid;
        nxt_word = in_word;
        if (rst_n) begin
            if (in_valid && !o_in_stall) begin
                due_replies.push_back(apply_console_cmd(in_word));
                n_accepted++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (feed_gap != 0) begin
                    feed_gap--;
                end else if (cmd_backlog.size() != 0) begin
                    nxt_word = cmd_backlog.pop_front();
                    nxt_valid = 1'b1;
                    feed_gap = idle_len();
                end
            end
        end
        in_valid <= nxt_valid;
        in_word <= nxt_word;
    end

    always @(posedge i_clk) begin : result_proc
        t_out_word want;
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (due_replies.size() == 0) begin
                    $display("%0t: result with nothing expected, got %h", $time, o_out_word);
                    n_errors++;
                end else begin
                    want = due_replies.pop_front();
                    n_checked++;
                    if (o_out_word.cursor_position !== want.cursor_position) begin
                        $display("%0t: cursor_position expected %0d actual %0d", $time,
                                 want.cursor_position, o_out_word.cursor_position);
                        n_errors++;
                    end
                    if (o_out_word.cell_data !== want.cell_data) begin
                        $display("%0t: cell_data expected %h actual %h", $time,
                                 want.cell_data, o_out_word.cell_data);
                        n_errors++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
            end else begin
                stall_left = idle_len();
            end
        end
        out_stall <= (stall_left != 0);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] ph_attr [PHASES];
        logic ph_mode [PHASES];
        int unsigned ph_nl [PHASES];
        bit ph_gaps [PHASES];
        for (int i = 0; i < CELLS; i++) begin
            screen_mem[i] = {FIXED_ATTR, BLANK_CHAR};
        end
        ph_attr = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'h1E, 8'($urandom_range(0, 255))};
        ph_mode = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        ph_nl = '{12, 1, 25, 25, 8, 3};
        ph_gaps = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        @(negedge i_clk);
        queue_cmd(OP_READ, 8'h00, 11'd0);
        queue_cmd(OP_READ, 8'hFF, 11'(CELLS - 1));
        queue_cmd(OP_READ, 8'h00, 11'(CELLS));
        queue_cmd(OP_READ, 8'h00, 11'h7FF);
        queue_cmd(OP_PUT, CH_BACKSPACE, 11'd0);
        queue_cmd(OP_PUT, 8'h00, 11'h7FF);
        queue_cmd(OP_PUT, 8'hFF, 11'd0);
        queue_cmd(OP_PUT, 8'h41, 11'd0);
        queue_cmd(OP_PUT, CH_BACKSPACE, 11'd0);
        queue_cmd(OP_READ, 8'h00, 11'd2);
        queue_cmd(OP_READ, 8'h00, 11'd1);
        queue_cmd(OP_READ, 8'h00, 11'd0);
        queue_cmd(OP_PUT, CH_NEWLINE, 11'd0);
        queue_cmd(OP_PUT, 8'h7E, 11'd0);
        queue_cmd(OP_READ, 8'h00, 11'(COLUMNS));
        queue_cmd(OP_UNUSED, 8'hFF, 11'h7FF);
        queue_cmd(OP_CLEAR, 8'h00, 11'd0);
        queue_cmd(OP_READ, 8'h00, 11'd0);
        queue_cmd(OP_READ, 8'h00, 11'(COLUMNS));
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            cfg_write(REG_MODE, {7'd0, ph_mode[p]});
            cfg_write(REG_ATTR, ph_attr[p]);
            @(negedge i_clk);
            gaps_on = ph_gaps[p];
            for (int n = 0; n < PHASE_WORDS; n++) begin
                cmd_backlog.push_back(random_cmd(ph_nl[p]));
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d results for %0d commands across %0d settings of both registers.",
                 n_checked, n_accepted, PHASES + 1);
        $display("Commands included %0d scrolls, %0d clears and %0d cell reads.",
                 n_scrolls, n_clears, n_reads);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
